// ----- sv/wnst_pkg.sv -----
// ----------------------------------------------------------------------------
// wnst_pkg
// shared types, action and status codes for the sorted neighbor table
// ----------------------------------------------------------------------------
package wnst_pkg;

    localparam int unsigned CAPACITY_DEF    = 64;
    localparam int unsigned ID_BITS_DEF     = 16;
    localparam int unsigned WEIGHT_BITS_DEF = 16;
    localparam int unsigned MAX_RESULTS     = 64;

    localparam int unsigned ACT_W   = 3;
    localparam int unsigned FID_W   = 16;
    localparam int unsigned FWT_W   = 16;
    localparam int unsigned LIM_W   = 7;
    localparam int unsigned ST_W    = 2;

    typedef logic [ACT_W-1:0] t_action;
    typedef logic [ST_W-1:0]  t_status;

    localparam t_action ACT_ADD   = 3'd0;
    localparam t_action ACT_ERASE = 3'd1;
    localparam t_action ACT_GET   = 3'd2;
    localparam t_action ACT_FIRST = 3'd3;
    localparam t_action ACT_ATLST = 3'd4;
    localparam t_action ACT_CLEAR = 3'd5;
    // unused codes, accepted and dropped
    localparam t_action ACT_RSVD0 = 3'd6;
    localparam t_action ACT_RSVD1 = 3'd7;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOTF  = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_EMPTY = 2'd3;

    typedef struct packed {
        t_action            action;
        logic [FID_W-1:0]   neighbor_id;
        logic [FWT_W-1:0]   weight;
        logic [LIM_W-1:0]   count_limit;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [FID_W-1:0]   entry_id;
        logic [FWT_W-1:0]   entry_weight;
        logic               last;
    } t_out_item;

endpackage

// ----- sv/wnst_if.sv -----
// ----------------------------------------------------------------------------
// wnst_in_if / wnst_out_if
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface wnst_in_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                action;
    logic [15:0]               neighbor_id;
    logic [15:0]               weight;
    logic [6:0]                count_limit;
    modport source (output valid, action, neighbor_id, weight, count_limit, input ready);
    modport sink   (input valid, action, neighbor_id, weight, count_limit, output ready);
endinterface

interface wnst_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [15:0]               entry_id;
    logic [15:0]               entry_weight;
    logic                      last;
    modport source (output valid, status, entry_id, entry_weight, last, input ready);
    modport sink   (input valid, status, entry_id, entry_weight, last, output ready);
endinterface

// ----- sv/wnst_ram.sv -----
// ----------------------------------------------------------------------------
// wnst_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module wnst_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- sv/wnst_front.sv -----
// ----------------------------------------------------------------------------
// wnst_front
// accepts command beats into a two-entry queue toward the table engine
// ----------------------------------------------------------------------------
module wnst_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    wnst_in_if.sink             s_in,
    output wnst_pkg::t_in_item  o_item,
    output logic                o_valid,
    input  logic                i_take
);
    import wnst_pkg::*;

    t_in_item r_q [2];
    logic     r_rd, r_wr;
    logic [1:0] r_cnt;
    logic     w_push, w_pop;

    assign s_in.ready = (r_cnt != 2'd2);
    assign w_push     = s_in.valid && s_in.ready && (s_in.action <= ACT_CLEAR);
    assign w_pop      = i_take && (r_cnt != 2'd0);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{s_in.action, s_in.neighbor_id, s_in.weight, s_in.count_limit};
        end
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ----- sv/wnst_back.sv -----
// ----------------------------------------------------------------------------
// wnst_back
// table engine: scans the sorted slots, shifts entries, streams results
// ----------------------------------------------------------------------------
module wnst_back #(
    parameter int unsigned CAPACITY    = 64,
    parameter int unsigned ID_BITS     = 16,
    parameter int unsigned WEIGHT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wnst_pkg::t_in_item  i_item,
    input  logic                i_valid,
    output logic                o_take,
    wnst_out_if.source          m_out
);
    import wnst_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    // longest list the table can produce
    localparam logic [CW-1:0] LIST_MAX = (CAPACITY < MAX_RESULTS) ? CW'(CAPACITY)
                                                                   : CW'(MAX_RESULTS);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1; // scan for id
    localparam logic [3:0] S_FOUND = 4'd2;
    localparam logic [3:0] S_RMV   = 4'd3; // shift up after removal
    localparam logic [3:0] S_INSP  = 4'd4; // scan for insert position
    localparam logic [3:0] S_INSS  = 4'd5; // shift down to open hole
    localparam logic [3:0] S_CNT   = 4'd6; // count qualifying entries
    localparam logic [3:0] S_LIST  = 4'd7; // stream list
    localparam logic [3:0] S_OUT   = 4'd8; // single result pending
    localparam logic [3:0] S_HOLE  = 4'd9; // write new entry into the hole

    logic [3:0]             r_state, n_state;
    logic [CW-1:0]          r_occ, n_occ;
    logic [CW-1:0]          r_idx, n_idx;   // address being read
    logic [CW-1:0]          r_pos, n_pos;
    logic                   r_rv, n_rv;     // read data belongs to r_idx-1 pass
    logic [CW-1:0]          r_ridx, n_ridx; // index of data on rdata
    logic [CW-1:0]          r_lim, n_lim;
    t_in_item               r_cmd, n_cmd;
    logic [WEIGHT_BITS-1:0] r_oldw, n_oldw;

    logic                   r_ov, n_ov;
    t_out_item              r_ob, n_ob;

    logic                   w_we;
    logic [AW-1:0]          w_waddr, w_raddr;
    logic [ID_BITS-1:0]     w_wid, w_rid;
    logic [WEIGHT_BITS-1:0] w_wwt, w_rwt;

    logic [ID_BITS-1:0]     w_cid;
    logic [WEIGHT_BITS-1:0] w_cwt;
    logic                   w_before, w_ofree;

    wnst_ram #(.WIDTH(ID_BITS), .DEPTH(CAPACITY)) u_ids (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wid),
        .i_raddr(w_raddr), .o_rdata(w_rid));
    wnst_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(CAPACITY)) u_wts (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wwt),
        .i_raddr(w_raddr), .o_rdata(w_rwt));

    assign w_cid    = ID_BITS'(r_cmd.neighbor_id);
    assign w_cwt    = WEIGHT_BITS'(r_cmd.weight);
    assign w_before = (w_rwt != w_cwt) ? (w_rwt > w_cwt) : (w_rid > w_cid);
    assign w_ofree  = !r_ov || m_out.ready;

    assign m_out.valid        = r_ov;
    assign m_out.status       = r_ob.status;
    assign m_out.entry_id     = r_ob.entry_id;
    assign m_out.entry_weight = r_ob.entry_weight;
    assign m_out.last         = r_ob.last;

    assign o_take = (r_state == S_IDLE) && w_ofree;

    always_comb begin
        n_state = r_state; n_occ = r_occ; n_idx = r_idx; n_pos = r_pos;
        n_rv = 1'b0; n_ridx = r_idx; n_lim = r_lim; n_cmd = r_cmd; n_oldw = r_oldw;
        n_ov = r_ov && !m_out.ready; n_ob = r_ob;
        w_we = 1'b0; w_waddr = r_pos[AW-1:0]; w_wid = w_rid; w_wwt = w_rwt;
        w_raddr = r_idx[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && w_ofree) begin
                    n_cmd = i_item;
                    n_idx = '0;
                    w_raddr = '0;
                    n_rv = 1'b1; n_ridx = '0;
                    unique case (i_item.action)
                        ACT_ADD, ACT_ERASE, ACT_GET: n_state = S_FIND;
                        ACT_FIRST: begin
                            if (32'(i_item.count_limit) > 32'(r_occ)) begin
                                n_lim = r_occ;
                            end else begin
                                n_lim = CW'(i_item.count_limit);
                            end
                            if (n_lim > LIST_MAX) n_lim = LIST_MAX;
                            n_state = S_LIST;
                        end
                        ACT_ATLST: n_state = S_CNT;
                        default: begin
                            n_occ = '0;
                            n_ov = 1'b1;
                            n_ob = '{ST_OK, i_item.neighbor_id, '0, 1'b1};
                            n_state = S_IDLE;
                        end
                    endcase
                    n_idx = CW'(1);
                end
            end
            S_FIND: begin
                n_rv = 1'b1; n_ridx = r_idx; n_idx = r_idx + 1'b1;
                if (r_ridx >= r_occ) begin
                    n_rv = 1'b0;
                    n_state = S_OUT;
                    priority case (r_cmd.action)
                        ACT_ADD: begin
                            if (r_occ >= CW'(CAPACITY)) begin
                                n_ob = '{ST_FULL, r_cmd.neighbor_id, r_cmd.weight, 1'b1};
                            end else begin
                                n_ob = '{ST_OK, r_cmd.neighbor_id, r_cmd.weight, 1'b1};
                                n_idx = '0; n_rv = 1'b1; n_ridx = '0;
                                w_raddr = '0; n_idx = CW'(1);
                                n_state = S_INSP;
                            end
                        end
                        default: n_ob = '{ST_NOTF, r_cmd.neighbor_id, '0, 1'b1};
                    endcase
                end else if (r_rv && w_rid == w_cid) begin
                    n_rv = 1'b0;
                    n_pos = r_ridx; n_oldw = w_rwt;
                    n_state = S_FOUND;
                end
            end
            S_FOUND: begin
                n_state = S_OUT;
                priority case (r_cmd.action)
                    ACT_GET:
                        n_ob = '{ST_OK, r_cmd.neighbor_id, FWT_W'(r_oldw), 1'b1};
                    ACT_ERASE: begin
                        n_ob = '{ST_OK, r_cmd.neighbor_id, FWT_W'(r_oldw), 1'b1};
                        w_raddr = AW'(r_pos + 1'b1);
                        n_idx = r_pos + 1'b1; n_state = S_RMV; n_rv = 1'b1;
                    end
                    default: begin
                        n_ob = '{ST_OK, r_cmd.neighbor_id, r_cmd.weight, 1'b1};
                        if (r_oldw != w_cwt) begin
                            w_raddr = AW'(r_pos + 1'b1);
                            n_idx = r_pos + 1'b1; n_state = S_RMV; n_rv = 1'b1;
                        end
                    end
                endcase
            end
            S_RMV: begin
                // data at r_pos+1 is on rdata; move it to r_pos
                if (r_idx >= r_occ) begin
                    n_occ = r_occ - 1'b1;
                    if (r_cmd.action == ACT_ADD) begin
                        w_raddr = '0; n_idx = CW'(1); n_rv = 1'b1; n_ridx = '0;
                        n_state = S_INSP;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    w_we = 1'b1;
                    n_pos = r_idx;
                    n_idx = r_idx + 1'b1;
                    w_raddr = AW'(r_idx + 1'b1);
                end
            end
            S_INSP: begin
                n_rv = 1'b1; n_ridx = r_idx; n_idx = r_idx + 1'b1;
                if (r_ridx >= r_occ || !w_before) begin
                    n_pos = r_ridx;
                    n_rv = 1'b0;
                    // shift down from the tail: read occ-1, write occ
                    if (r_occ == r_ridx) begin
                        w_we = 1'b1; w_waddr = AW'(r_ridx);
                        w_wid = w_cid; w_wwt = w_cwt;
                        n_occ = r_occ + 1'b1;
                        n_state = S_OUT;
                    end else begin
                        w_raddr = AW'(r_occ - 1'b1);
                        n_idx = r_occ - 1'b1;
                        n_state = S_INSS;
                    end
                end
            end
            S_INSS: begin
                // slot r_idx is on rdata; move it one slot down
                w_we = 1'b1; w_waddr = AW'(r_idx + 1'b1);
                if (r_idx == r_pos) begin
                    n_state = S_HOLE;
                end else begin
                    w_raddr = AW'(r_idx - 1'b1);
                    n_idx = r_idx - 1'b1;
                end
            end
            S_HOLE: begin
                w_we = 1'b1;
                w_wid = w_cid; w_wwt = w_cwt;
                n_occ = r_occ + 1'b1;
                n_state = S_OUT;
            end
            S_CNT: begin
                n_rv = 1'b1; n_ridx = r_idx; n_idx = r_idx + 1'b1;
                if (r_ridx >= r_occ || w_rwt < w_cwt) begin
                    n_lim = (r_ridx > LIST_MAX) ? LIST_MAX : r_ridx;
                    w_raddr = '0; n_idx = CW'(1); n_ridx = '0;
                    n_state = S_LIST;
                end
            end
            S_LIST: begin
                n_rv = r_rv; n_ridx = r_ridx;
                if (r_lim == '0) begin
                    if (w_ofree) begin
                        n_ov = 1'b1; n_ob = '{ST_EMPTY, '0, '0, 1'b1};
                        n_state = S_IDLE;
                    end
                end else if (w_ofree) begin
                    n_ov = 1'b1;
                    n_ob = '{ST_OK, FID_W'(w_rid), FWT_W'(w_rwt),
                             (r_ridx + 1'b1 == r_lim)};
                    n_ridx = r_idx; n_idx = r_idx + 1'b1;
                    if (r_ridx + 1'b1 == r_lim) n_state = S_IDLE;
                end else begin
                    w_raddr = AW'(r_ridx);
                end
            end
            default: begin // S_OUT
                if (w_ofree) begin
                    n_ov = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_pos <= n_pos; r_ridx <= n_ridx; r_lim <= n_lim;
        r_oldw <= n_oldw; r_ob <= n_ob; r_idx <= n_idx;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_occ <= '0; r_rv <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_occ <= n_occ; r_rv <= n_rv; r_ov <= n_ov;
        end
    end
endmodule

// ----- sv/weighted_neighbor_sorted_table.sv -----
// ----------------------------------------------------------------------------
// weighted_neighbor_sorted_table
// sorted neighbor table, ordered by weight then id, with list streaming
// ----------------------------------------------------------------------------
// channel   dir  handshake     beat
// s_in      in   valid/ready   action, neighbor_id, weight, count_limit
// m_out     out  valid/ready   status, entry_id, entry_weight, last
//
// lookups scan the ram one slot a cycle until the id or the end of the table
// add/erase add a shift pass of one slot a cycle over the moved tail,
// and an insert writes the new slot in a final step after the shift
// first-n lists stream one beat a cycle at once while m_out is ready;
// at-least lists scan the qualifying prefix first
// reset: synchronous active low, clears occupancy and queue; ram is not cleared
// stalls: a two-beat queue decouples s_in from the engine; m_out backpressure
// holds the engine
// ----------------------------------------------------------------------------
module weighted_neighbor_sorted_table #(
    parameter int unsigned CAPACITY    = wnst_pkg::CAPACITY_DEF,
    parameter int unsigned ID_BITS     = wnst_pkg::ID_BITS_DEF,
    parameter int unsigned WEIGHT_BITS = wnst_pkg::WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wnst_in_if.sink     s_in,
    wnst_out_if.source  m_out
);
    import wnst_pkg::*;

    t_in_item w_item;
    logic     w_valid, w_take;

    // front: queue of accepted commands
    wnst_front u_front (
        .i_clk, .i_rst_n, .s_in, .o_item(w_item), .o_valid(w_valid), .i_take(w_take));

    // back: table engine over the id and weight rams
    wnst_back #(.CAPACITY(CAPACITY), .ID_BITS(ID_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_item(w_item), .i_valid(w_valid), .o_take(w_take), .m_out);
endmodule

// ----- sv/wnst_checker.sv -----
// ----------------------------------------------------------------------------
// wnst_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
module wnst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_status,
    input logic [15:0] i_id,
    input logic [15:0] i_wt,
    input logic        i_last
);
    import wnst_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_id) && $stable(i_last))
        else $error("result changed under stall");
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_EMPTY |-> i_last && i_id == '0 && i_wt == '0)
        else $error("empty status malformed");
    a_notf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == ST_NOTF |-> i_last && i_wt == '0)
        else $error("not found malformed");
endmodule

bind weighted_neighbor_sorted_table wnst_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(m_out.valid), .i_ready(m_out.ready),
    .i_status(m_out.status), .i_id(m_out.entry_id), .i_wt(m_out.entry_weight),
    .i_last(m_out.last));

// ----- bench/tb_neighbor_ledger.sv -----
// ----------------------------------------------------------------------------
// tb_neighbor_ledger
// expected-beat store and in-order checker for the sorted neighbor table
// ----------------------------------------------------------------------------
class neighbor_ledger;
    localparam int unsigned CAP = wnst_pkg::CAPACITY_DEF;

    logic [15:0] ids[CAP];
    logic [15:0] wts[CAP];
    int unsigned occ;
    wnst_pkg::t_out_item pending[$];
    int unsigned mismatches;
    int unsigned beats_checked;
    int unsigned lists_seen;
    int unsigned full_seen;

    function new();
        occ = 0;
        mismatches = 0;
        beats_checked = 0;
        lists_seen = 0;
        full_seen = 0;
    endfunction

    function void push(wnst_pkg::t_status st, logic [15:0] id, logic [15:0] w, logic lst);
        wnst_pkg::t_out_item b;
        b.status = st;
        b.entry_id = id;
        b.entry_weight = w;
        b.last = lst;
        pending = {pending, b};
    endfunction

    function int unsigned slot_of(logic [15:0] id);
        for (int unsigned i = 0; i < occ; i++)
            if (ids[i] == id) return i;
        return occ;
    endfunction

    function void drop_slot(int unsigned pos);
        for (int unsigned i = pos; i + 1 < occ; i++) begin
            ids[i] = ids[i+1];
            wts[i] = wts[i+1];
        end
        occ--;
    endfunction

    function void place(logic [15:0] id, logic [15:0] w);
        int unsigned pos;
        pos = 0;
        while (pos < occ && (wts[pos] > w || (wts[pos] == w && ids[pos] > id))) pos++;
        for (int unsigned i = occ; i > pos; i--) begin
            ids[i] = ids[i-1];
            wts[i] = wts[i-1];
        end
        ids[pos] = id;
        wts[pos] = w;
        occ++;
    endfunction

    function void stream_prefix(int unsigned n);
        if (n > occ) n = occ;
        if (n > wnst_pkg::MAX_RESULTS) n = wnst_pkg::MAX_RESULTS;
        lists_seen++;
        if (n == 0) begin
            push(wnst_pkg::ST_EMPTY, 16'd0, 16'd0, 1'b1);
            return;
        end
        for (int unsigned i = 0; i < n; i++)
            push(wnst_pkg::ST_OK, ids[i], wts[i], i + 1 == n);
    endfunction

    // apply one accepted command beat and queue its result beats
    function void note_command(wnst_pkg::t_in_item c);
        int unsigned pos;
        int unsigned n;
        logic [15:0] old;
        pos = slot_of(c.neighbor_id);
        case (c.action)
            wnst_pkg::ACT_ADD: begin
                if (pos < occ) begin
                    if (wts[pos] != c.weight) begin
                        drop_slot(pos);
                        place(c.neighbor_id, c.weight);
                    end
                    push(wnst_pkg::ST_OK, c.neighbor_id, c.weight, 1'b1);
                end else if (occ >= CAP) begin
                    full_seen++;
                    push(wnst_pkg::ST_FULL, c.neighbor_id, c.weight, 1'b1);
                end else begin
                    place(c.neighbor_id, c.weight);
                    push(wnst_pkg::ST_OK, c.neighbor_id, c.weight, 1'b1);
                end
            end
            wnst_pkg::ACT_ERASE: begin
                if (pos < occ) begin
                    old = wts[pos];
                    drop_slot(pos);
                    push(wnst_pkg::ST_OK, c.neighbor_id, old, 1'b1);
                end else begin
                    push(wnst_pkg::ST_NOTF, c.neighbor_id, 16'd0, 1'b1);
                end
            end
            wnst_pkg::ACT_GET: begin
                if (pos < occ) push(wnst_pkg::ST_OK, c.neighbor_id, wts[pos], 1'b1);
                else push(wnst_pkg::ST_NOTF, c.neighbor_id, 16'd0, 1'b1);
            end
            wnst_pkg::ACT_FIRST: stream_prefix(c.count_limit);
            wnst_pkg::ACT_ATLST: begin
                n = 0;
                while (n < occ && wts[n] >= c.weight) n++;
                stream_prefix(n);
            end
            wnst_pkg::ACT_CLEAR: begin
                occ = 0;
                push(wnst_pkg::ST_OK, c.neighbor_id, 16'd0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function void check_beat(wnst_pkg::t_out_item got);
        wnst_pkg::t_out_item want;
        beats_checked++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: st=%0d id=%h w=%h last=%0b",
                         got.status, got.entry_id, got.entry_weight, got.last);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("beat %0d mismatch: want st=%0d id=%h w=%h last=%0b, got st=%0d id=%h w=%h last=%0b",
                         beats_checked, want.status, want.entry_id, want.entry_weight,
                         want.last, got.status, got.entry_id, got.entry_weight, got.last);
        end
    endfunction
endclass

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// random and directed command traffic against the sorted neighbor table
// ----------------------------------------------------------------------------
// a directed pass covers extremes, every action, full table, ties, long and
// empty lists, then random traffic works a small id pool so hits are common
// both channels idle at random; every result beat is compared in order
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wnst_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 10000000;
    localparam int unsigned RANDOM_CMDS = 272;

    logic i_clk;
    logic i_rst_n;
    int unsigned cycle_count;
    logic sink_hold;   // when set the result side stays ready high

    wnst_in_if  cmd_ch();
    wnst_out_if res_ch();

    neighbor_ledger ledger;

    weighted_neighbor_sorted_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (cmd_ch.sink),
        .m_out   (res_ch.source)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // short gaps mostly, now and then a long one
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("weighted_neighbor_sorted_table test failed");
            $finish;
        end
    end

    // result side: random ready, check each accepted beat
    always @(posedge i_clk) begin
        t_out_item b;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            b.status = res_ch.status;
            b.entry_id = res_ch.entry_id;
            b.entry_weight = res_ch.entry_weight;
            b.last = res_ch.last;
            ledger.check_beat(b);
        end
    end

    initial begin
        int unsigned g;
        forever begin
            @(posedge i_clk);
            g = gap_len();
            if (sink_hold || g == 0 || $urandom_range(0, 3) != 0) begin
                res_ch.ready <= 1'b1;
            end else begin
                res_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
                res_ch.ready <= 1'b1;
            end
        end
    end

    // one command beat; valid stays up until accepted, then an optional gap
    task automatic send_cmd(t_action act, logic [15:0] id, logic [15:0] w, logic [6:0] lim);
        int unsigned g;
        t_in_item c;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.action      <= act;
        cmd_ch.neighbor_id <= id;
        cmd_ch.weight      <= w;
        cmd_ch.count_limit <= lim;
        do @(posedge i_clk); while (!cmd_ch.ready);
        c.action = act;
        c.neighbor_id = id;
        c.weight = w;
        c.count_limit = lim;
        ledger.note_command(c);
        g = gap_len();
        if (g != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned r;
        int unsigned drain;
        logic [15:0] id;
        logic [15:0] w;
        ledger = new();
        cycle_count = 0;
        sink_hold = 1'b0;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.action = ACT_ADD;
        cmd_ch.neighbor_id = '0;
        cmd_ch.weight = '0;
        cmd_ch.count_limit = '0;
        res_ch.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table behavior
        send_cmd(ACT_FIRST, 16'h0000, 16'h0000, 7'd64);
        send_cmd(ACT_ATLST, 16'h0000, 16'h0000, 7'd0);
        send_cmd(ACT_GET, 16'hFFFF, 16'h0000, 7'd0);
        send_cmd(ACT_ERASE, 16'h0000, 16'h0000, 7'd0);
        // extremes and ties on weight
        send_cmd(ACT_ADD, 16'hFFFF, 16'hFFFF, 7'h7F);
        send_cmd(ACT_ADD, 16'h0000, 16'h0000, 7'd0);
        send_cmd(ACT_ADD, 16'h1234, 16'h8000, 7'd0);
        send_cmd(ACT_ADD, 16'h4321, 16'h8000, 7'd0);
        send_cmd(ACT_ADD, 16'h1234, 16'h8000, 7'd0);   // same weight, no change
        send_cmd(ACT_ADD, 16'h1234, 16'h0001, 7'd0);   // re-placed lower
        send_cmd(ACT_GET, 16'h4321, 16'h0000, 7'd0);
        send_cmd(ACT_FIRST, 16'h0000, 16'h0000, 7'd0); // count zero
        send_cmd(ACT_FIRST, 16'h0000, 16'h0000, 7'd2);
        send_cmd(ACT_ATLST, 16'h0000, 16'h0000, 7'd0); // all qualify
        send_cmd(ACT_ATLST, 16'h0000, 16'hFFFF, 7'd0);
        send_cmd(ACT_RSVD0, 16'hAAAA, 16'h5555, 7'h55); // unused codes ignored
        send_cmd(ACT_RSVD1, 16'h5555, 16'hAAAA, 7'h2A);
        send_cmd(ACT_ERASE, 16'hFFFF, 16'h0000, 7'd0);
        send_cmd(ACT_CLEAR, 16'hBEEF, 16'h1111, 7'd0);
        // fill to capacity, then overflow and long lists
        for (int unsigned i = 0; i < 64; i++)
            send_cmd(ACT_ADD, 16'(i * 997), 16'($urandom_range(0, 7)), 7'd0);
        send_cmd(ACT_ADD, 16'hFFFE, 16'h7777, 7'd0);
        send_cmd(ACT_ADD, 16'd997, 16'hFFFF, 7'd0);    // update while full
        send_cmd(ACT_FIRST, 16'h0000, 16'h0000, 7'h7F);
        send_cmd(ACT_ATLST, 16'h0000, 16'h0000, 7'd0);
        send_cmd(ACT_CLEAR, 16'h0000, 16'h0000, 7'd0);

        // random: small id and weight pools keep hits and ties frequent
        for (int unsigned k = 0; k < RANDOM_CMDS; k++) begin
            r = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 47));
            w = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
            if (r < 50) send_cmd(ACT_ADD, id, w, 7'($urandom));
            else if (r < 62) send_cmd(ACT_ERASE, id, w, 7'($urandom));
            else if (r < 74) send_cmd(ACT_GET, id, w, 7'($urandom));
            else if (r < 84) send_cmd(ACT_FIRST, id, w, 7'($urandom_range(0, 70)));
            else if (r < 94) send_cmd(ACT_ATLST, id, w, 7'($urandom));
            else if (r < 97) send_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom), 7'($urandom));
            else send_cmd(($urandom_range(0, 1) == 0) ? ACT_RSVD0 : ACT_RSVD1,
                          16'($urandom), 16'($urandom), 7'($urandom));
        end
        send_idle();

        // drain: wait for every expected beat, then some settle time
        sink_hold = 1'b1;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 200) begin
            @(posedge i_clk);
            drain++;
        end

        $display("ran %0d checked beats over %0d lists, %0d full-table rejects",
                 ledger.beats_checked, ledger.lists_seen, ledger.full_seen);
        if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
            $display("weighted_neighbor_sorted_table test passed");
        end else begin
            $display("%0d mismatches", ledger.mismatches);
            $display("weighted_neighbor_sorted_table test failed");
        end
        $finish;
    end
endmodule
